[rtl/core/nps_pkg.sv]
// Shared constants and types of the nearest palette colour search.
`default_nettype none

package nps_pkg;

	// Defaults for the top-level parameters
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int CHANNEL_BITS_DEF  = 16;

	// Fixed widths of the channel payload fields
	localparam int PORT_CHAN_BITS  = 16;
	localparam int PORT_INDEX_BITS = 8;
	localparam int CFG_BITS        = 9;
	localparam int DIST_BITS       = 48;

	// Reset value of the entries-in-use register
	localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd256;

	// Luminance weights 0.30, 0.59 and 0.11 scaled by 100
	localparam int WEIGHT_RED   = 30;
	localparam int WEIGHT_GREEN = 59;
	localparam int WEIGHT_BLUE  = 11;
	// All weights are below 64
	localparam int WEIGHT_BITS  = 6;

	// Action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Control that travels with one palette entry through the distance pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} nps_tag_t;

endpackage

`default_nettype wire

[rtl/core/nps_if.sv]
// Request and result channel interfaces of the nearest palette colour search.
`default_nettype none

interface nps_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  entry_index;
	logic [15:0] red_value;
	logic [15:0] green_value;
	logic [15:0] blue_value;

	modport source (output valid, action, entry_index, red_value, green_value, blue_value,
		input ready);
	modport sink (input valid, action, entry_index, red_value, green_value, blue_value,
		output ready);
endinterface

interface nps_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  best_index;
	logic [15:0] best_red;
	logic [15:0] best_green;
	logic [15:0] best_blue;
	logic [47:0] best_distance;

	modport source (output valid, best_index, best_red, best_green, best_blue, best_distance,
		input ready);
	modport sink (input valid, best_index, best_red, best_green, best_blue, best_distance,
		output ready);
endinterface

`default_nettype wire

[rtl/core/nps_palette_ram.sv]
// Palette memory: one write port, one registered read port.
`default_nettype none

module nps_palette_ram #(
	parameter int DEPTH = nps_pkg::PALETTE_DEPTH_DEF,
	parameter int WIDTH = 3 * nps_pkg::CHANNEL_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire  [$clog2(DEPTH)-1:0] wr_addr,
	input  wire  [WIDTH-1:0]         wr_data,
	input  wire                      rd_en,
	input  wire  [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/nps_dist_unit.sv]
// Pipelined weighted squared distance unit: difference, weighting, squaring, sum.
`default_nettype none

module nps_dist_unit #(
	parameter int CHANNEL_BITS = nps_pkg::CHANNEL_BITS_DEF,
	parameter int IDX_BITS     = 8
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [CHANNEL_BITS-1:0]        query_r,
	input  wire  [CHANNEL_BITS-1:0]        query_g,
	input  wire  [CHANNEL_BITS-1:0]        query_b,
	input  wire  [3*CHANNEL_BITS-1:0]      entry_s1,
	input  nps_pkg::nps_tag_t              tag_s1,
	input  wire  [IDX_BITS-1:0]            idx_s1,
	output nps_pkg::nps_tag_t              tag_s4,
	output logic [IDX_BITS-1:0]            idx_s4,
	output logic [3*CHANNEL_BITS-1:0]      entry_s4,
	output logic [nps_pkg::DIST_BITS-1:0]  dist_s4
);

	localparam int CB = CHANNEL_BITS;
	localparam int WW = CHANNEL_BITS + nps_pkg::WEIGHT_BITS;
	localparam int SW = 2 * WW;

	logic [CB-1:0] ent_r, ent_g, ent_b;
	logic [CB-1:0] dr, dg, db;

	nps_pkg::nps_tag_t   tag_s2, tag_s3;
	logic [IDX_BITS-1:0] idx_s2, idx_s3;
	logic [3*CB-1:0]     entry_s2, entry_s3;
	logic [WW-1:0]       wr_s2, wg_s2, wb_s2;
	logic [SW-1:0]       sq_r, sq_g, sq_b;
	logic [SW-1:0]       sq_r_s3, sq_g_s3, sq_b_s3;

	assign ent_r = entry_s1[3*CB-1:2*CB];
	assign ent_g = entry_s1[2*CB-1:CB];
	assign ent_b = entry_s1[CB-1:0];

	assign dr = (query_r > ent_r) ? (query_r - ent_r) : (ent_r - query_r);
	assign dg = (query_g > ent_g) ? (query_g - ent_g) : (ent_g - query_g);
	assign db = (query_b > ent_b) ? (query_b - ent_b) : (ent_b - query_b);

	assign sq_r = SW'(wr_s2) * SW'(wr_s2);
	assign sq_g = SW'(wg_s2) * SW'(wg_s2);
	assign sq_b = SW'(wb_s2) * SW'(wb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		// Weighting by the small constants
		wr_s2    <= WW'(dr) * WW'(nps_pkg::WEIGHT_RED);
		wg_s2    <= WW'(dg) * WW'(nps_pkg::WEIGHT_GREEN);
		wb_s2    <= WW'(db) * WW'(nps_pkg::WEIGHT_BLUE);
		idx_s2   <= idx_s1;
		entry_s2 <= entry_s1;

		sq_r_s3  <= sq_r;
		sq_g_s3  <= sq_g;
		sq_b_s3  <= sq_b;
		idx_s3   <= idx_s2;
		entry_s3 <= entry_s2;

		dist_s4  <= nps_pkg::DIST_BITS'(sq_r_s3) + nps_pkg::DIST_BITS'(sq_g_s3)
			+ nps_pkg::DIST_BITS'(sq_b_s3);
		idx_s4   <= idx_s3;
		entry_s4 <= entry_s3;
	end

endmodule

`default_nettype wire

[rtl/core/nearest_palette_color_search_core.sv]
// Top level of the nearest palette colour search: sequencer, best-match tracking, result register.
`default_nettype none

// Channel   Dir  Carries
// req       in   action, entry_index, red/green/blue_value (palette write or query)
// rsp       out  best_index, best_red/green/blue, best_distance (one per query)
// cfg_we    in   write strobe of entries_in_use, data on cfg_wdata
//
// A query scans the clamped entries_in_use entries: the sequencer walks the
// palette memory's single read port one entry per cycle, and the distance
// pipeline's weighting, squaring and sum registers follow the read.
// req.ready is high only while the sequencer is idle; a finished result waits in
// the output register, so a new transfer may be taken while it is still unread.
// arst_n clears the control state; palette contents are undefined until written.

module nearest_palette_color_search_core #(
	parameter int PALETTE_DEPTH = nps_pkg::PALETTE_DEPTH_DEF,
	parameter int CHANNEL_BITS  = nps_pkg::CHANNEL_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	nps_req_if.sink                      req,
	nps_rsp_if.source                    rsp,
	input  wire                          cfg_we,
	input  wire  [nps_pkg::CFG_BITS-1:0] cfg_wdata
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CB = CHANNEL_BITS;

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                  state_q;
	logic [nps_pkg::CFG_BITS-1:0] entries_q;
	logic [AW-1:0]               addr_q;
	logic [AW-1:0]               last_q;
	logic [CB-1:0]               qr_q, qg_q, qb_q;

	logic                        req_xfer;
	logic                        rsp_xfer;
	logic                        wr_en;
	logic [31:0]                 wr_idx_ext;
	logic [31:0]                 cfg_ext;
	logic [31:0]                 lim;
	logic [31:0]                 lim_m1;
	logic [CB-1:0]               in_r, in_g, in_b;
	logic                        load_out;

	logic [3*CB-1:0]             entry_s1;
	nps_pkg::nps_tag_t           tag_s1;
	logic [AW-1:0]               idx_s1;
	nps_pkg::nps_tag_t           tag_s4;
	logic [AW-1:0]               idx_s4;
	logic [3*CB-1:0]             entry_s4;
	logic [nps_pkg::DIST_BITS-1:0] dist_s4;

	logic [AW-1:0]               best_idx_q;
	logic [3*CB-1:0]             best_col_q;
	logic [nps_pkg::DIST_BITS-1:0] best_dist_q;
	logic [31:0]                 best_idx_ext;

	logic                        out_valid_q;
	logic [nps_pkg::PORT_INDEX_BITS-1:0] out_idx_q;
	logic [nps_pkg::PORT_CHAN_BITS-1:0]  out_r_q, out_g_q, out_b_q;
	logic [nps_pkg::DIST_BITS-1:0]       out_dist_q;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp_xfer  = out_valid_q && rsp.ready;

	// Only the low channel bits are kept, on writes and on queries alike
	assign in_r = req.red_value[CB-1:0];
	assign in_g = req.green_value[CB-1:0];
	assign in_b = req.blue_value[CB-1:0];

	// A write beyond the palette is dropped
	assign wr_idx_ext = 32'(req.entry_index);
	assign wr_en      = req_xfer && (req.action == nps_pkg::ACT_WRITE)
		&& (wr_idx_ext < 32'(PALETTE_DEPTH));

	// Entries searched: zero counts as one, anything above the depth saturates
	assign cfg_ext = 32'(entries_q);
	always_comb begin
		if (cfg_ext == 32'd0) begin
			lim = 32'd1;
		end else if (cfg_ext > 32'(PALETTE_DEPTH)) begin
			lim = 32'(PALETTE_DEPTH);
		end else begin
			lim = cfg_ext;
		end
	end
	assign lim_m1 = lim - 32'd1;

	// The finished match moves to the output register once that is free
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= nps_pkg::CFG_RESET;
		end else if (cfg_we) begin
			entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			tag_s1  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					tag_s1 <= '0;
					if (req_xfer && (req.action == nps_pkg::ACT_QUERY)) begin
						addr_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// One palette read per cycle; the tag follows the read data
					tag_s1.valid <= 1'b1;
					tag_s1.first <= (addr_q == '0);
					tag_s1.last  <= (addr_q == last_q);
					if (addr_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					tag_s1 <= '0;
					if (tag_s4.valid && tag_s4.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					tag_s1 <= '0;
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					tag_s1  <= '0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query colour and scan limit are held for the whole scan
	always_ff @(posedge clk) begin
		if (req_xfer && (req.action == nps_pkg::ACT_QUERY)) begin
			qr_q   <= in_r;
			qg_q   <= in_g;
			qb_q   <= in_b;
			last_q <= lim_m1[AW-1:0];
		end
		idx_s1 <= addr_q;
	end

	nps_palette_ram #(
		.DEPTH (PALETTE_DEPTH),
		.WIDTH (3 * CB)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_ext[AW-1:0]),
		.wr_data ({in_r, in_g, in_b}),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (addr_q),
		.rd_data (entry_s1)
	);

	nps_dist_unit #(
		.CHANNEL_BITS (CB),
		.IDX_BITS     (AW)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.query_r  (qr_q),
		.query_g  (qg_q),
		.query_b  (qb_q),
		.entry_s1 (entry_s1),
		.tag_s1   (tag_s1),
		.idx_s1   (idx_s1),
		.tag_s4   (tag_s4),
		.idx_s4   (idx_s4),
		.entry_s4 (entry_s4),
		.dist_s4  (dist_s4)
	);

	// The first entry always seeds the match; later ones replace it only when
	// strictly closer, so the lowest index wins a tie.
	always_ff @(posedge clk) begin
		if (tag_s4.valid && (tag_s4.first || (dist_s4 < best_dist_q))) begin
			best_idx_q  <= idx_s4;
			best_col_q  <= entry_s4;
			best_dist_q <= dist_s4;
		end
	end

	assign best_idx_ext = 32'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q  <= best_idx_ext[nps_pkg::PORT_INDEX_BITS-1:0];
			out_r_q    <= nps_pkg::PORT_CHAN_BITS'(best_col_q[3*CB-1:2*CB]);
			out_g_q    <= nps_pkg::PORT_CHAN_BITS'(best_col_q[2*CB-1:CB]);
			out_b_q    <= nps_pkg::PORT_CHAN_BITS'(best_col_q[CB-1:0]);
			out_dist_q <= best_dist_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.best_index    = out_idx_q;
	assign rsp.best_red      = out_r_q;
	assign rsp.best_green    = out_g_q;
	assign rsp.best_blue     = out_b_q;
	assign rsp.best_distance = out_dist_q;

`ifndef SYNTH
	// Palette read data only arrives while a scan is running or draining
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("palette read outside a scan");

	// The scan address never passes the last entry searched
	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= last_q))
		else $error("scan address beyond the clamped entry count");

	// The last compare always ends the scan
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s4.valid && tag_s4.last) |=> (state_q == ST_DONE))
		else $error("last entry compared but no result pending");

	// A result appears only from a finished search
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised without a finished search");
`endif

endmodule

`default_nettype wire
